// ===== sv/bear_pkg.sv =====
// ----------------------------------------------------------------------------
// bear_pkg: shared types and constants for button edge and auto-repeat
// Field widths, timer constants, register indexes and the channel result type.
// ----------------------------------------------------------------------------
package bear_pkg;

    localparam int BTN_W      = 16;
    localparam int TICK_W     = 10;
    localparam int TIMER_W    = 16;
    localparam int DEADLINE_W = 17;
    localparam int DELAY_W    = 16;
    localparam int INTERVAL_W = 15;
    localparam int CFG_IDX_W  = 1;
    localparam int CFG_DATA_W = 16;

    localparam int IN_TDATA_W  = 48;
    localparam int IN_TUSER_W  = 2;
    localparam int OUT_TDATA_W = 104;

    localparam logic [BTN_W-1:0]      CORE_MASK   = 16'h9FFF;
    localparam logic [DEADLINE_W-1:0] TIMER_WRAP  = 17'd40000;
    localparam logic [DEADLINE_W-1:0] TIMER_FOLD  = 17'd20000;
    localparam logic [DELAY_W-1:0]    DELAY_RESET = 16'd40000;

    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_DELAY    = 1'b0;
    localparam logic [CFG_IDX_W-1:0] CFG_REPEAT_INTERVAL = 1'b1;

    typedef struct packed {
        logic [BTN_W-1:0] hold;
        logic [BTN_W-1:0] press;
        logic [BTN_W-1:0] release_;
        logic             repeat_;
    } t_chan_res;

endpackage

// ===== sv/bear_chan.sv =====
// ----------------------------------------------------------------------------
// bear_chan: one button channel with edge detect and repeat timer
// Holds last buttons, repeat timer and next deadline; computes the results of
// one poll combinationally and commits the state when the poll is taken.
// ----------------------------------------------------------------------------
module bear_chan (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_step,
    input  logic                           i_reload,
    input  logic [bear_pkg::DELAY_W-1:0]   i_reload_delay,
    input  logic [bear_pkg::DELAY_W-1:0]   i_delay,
    input  logic [bear_pkg::INTERVAL_W-1:0] i_interval,
    input  logic [bear_pkg::BTN_W-1:0]     i_buttons,
    input  logic [bear_pkg::TICK_W-1:0]    i_ticks,
    output bear_pkg::t_chan_res            o_res,
    output logic [bear_pkg::BTN_W-1:0]     o_last_hold
);
    import bear_pkg::*;

    logic [BTN_W-1:0]      r_last_hold;
    logic [TIMER_W-1:0]    r_timer;
    logic [DEADLINE_W-1:0] r_deadline;
    logic [TIMER_W-1:0]    n_timer;
    logic [DEADLINE_W-1:0] n_deadline;

    logic [BTN_W-1:0]      diff;
    logic [BTN_W-1:0]      press;
    logic [BTN_W-1:0]      release_bits;
    logic [DEADLINE_W-1:0] t_sum;
    logic [DEADLINE_W-1:0] t_wrap;
    logic [DEADLINE_W-1:0] t_fold;
    logic [DEADLINE_W-1:0] d_add;
    logic                  rep;

    assign diff         = i_buttons ^ r_last_hold;
    assign press        = diff & i_buttons;
    assign release_bits = diff & r_last_hold;

    assign t_sum  = {1'b0, r_timer} + DEADLINE_W'(i_ticks);
    assign t_wrap = (t_sum >= TIMER_WRAP) ? (t_sum - TIMER_WRAP) : t_sum;
    assign t_fold = t_wrap - TIMER_FOLD;
    assign d_add  = r_deadline + DEADLINE_W'(i_interval);

    always_comb begin
        n_timer    = r_timer;
        n_deadline = r_deadline;
        rep        = 1'b0;
        if ((|press) || (|release_bits)) begin
            // any edge restarts the timer
            n_timer    = '0;
            n_deadline = DEADLINE_W'(i_delay);
            rep        = (|press) && (|i_interval);
        end else if (|i_buttons) begin
            n_timer = t_wrap[TIMER_W-1:0];
            if (t_wrap >= r_deadline) begin
                rep = 1'b1;
                if (t_wrap >= TIMER_FOLD) begin
                    n_timer    = t_fold[TIMER_W-1:0];
                    n_deadline = d_add - TIMER_FOLD;
                end else begin
                    n_deadline = d_add;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_last_hold <= '0;
            r_timer     <= '0;
            r_deadline  <= DEADLINE_W'(DELAY_RESET);
        end else if (i_reload) begin
            r_timer     <= '0;
            r_deadline  <= DEADLINE_W'(i_reload_delay);
        end else if (i_step) begin
            r_last_hold <= i_buttons;
            r_timer     <= n_timer;
            r_deadline  <= n_deadline;
        end
    end

    assign o_res.hold     = i_buttons;
    assign o_res.press    = press;
    assign o_res.release_ = release_bits;
    assign o_res.repeat_  = rep;
    assign o_last_hold    = r_last_hold;

endmodule

// ===== sv/button_edge_and_auto_repeat_top.sv =====
// ----------------------------------------------------------------------------
// button_edge_and_auto_repeat_top: button edges and auto-repeat, two channels
// Input register, per-channel edge and repeat logic, and a result register.
// ----------------------------------------------------------------------------
// Usage:
//   Each poll enters on the s_axis channel: core and extension button words
//   and the elapsed ticks in tdata, the present and suppress flags in tuser.
//   One result per poll leaves on the m_axis channel with held, pressed and
//   released bits and a repeat flag for each channel.
//   A poll passes through the input register and then the result register.
//   One poll is taken every cycle while the receiver does not stall; the
//   channel state (last buttons, timer, deadline) is read and written
//   between the input register and the result register.
//   When the receiver stalls, the result register holds and the input
//   register still takes one more poll; after that tready drops until the
//   result is transferred.
//   Reset clears both channels, sets repeat_delay to 40000 and
//   repeat_interval to 0. A register write clears both timers and reloads
//   both deadlines with repeat_delay; write only while the block is idle.
//   With the extension absent, its result fields repeat the previous ones.
// ----------------------------------------------------------------------------
module button_edge_and_auto_repeat_top (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // config write port
    input  logic                              i_cfg_we,
    input  logic [bear_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [bear_pkg::CFG_DATA_W-1:0]   i_cfg_wdata,
    // poll input
    input  logic                              i_s_tvalid,
    output logic                              o_s_tready,
    // core_buttons[15:0], ext_buttons[31:16], elapsed_ticks[41:32], zero pad
    input  logic [bear_pkg::IN_TDATA_W-1:0]   i_s_tdata,
    // ext_present[0], ext_suppress[1]
    input  logic [bear_pkg::IN_TUSER_W-1:0]   i_s_tuser,
    // result output
    output logic                              o_m_tvalid,
    input  logic                              i_m_tready,
    // core_hold[15:0], core_press[31:16], core_release[47:32], core_repeat[48],
    // ext_hold[64:49], ext_press[80:65], ext_release[96:81], ext_repeat[97],
    // zero pad
    output logic [bear_pkg::OUT_TDATA_W-1:0]  o_m_tdata
);
    import bear_pkg::*;

    logic [DELAY_W-1:0]    r_delay;
    logic [INTERVAL_W-1:0] r_interval;
    logic                  cfg_reload;
    logic [DELAY_W-1:0]    reload_delay;

    logic                  r_in_valid;
    logic [BTN_W-1:0]      r_in_core;
    logic [BTN_W-1:0]      r_in_ext;
    logic [TICK_W-1:0]     r_in_ticks;
    logic                  r_in_present;
    logic                  r_in_suppress;

    logic                  r_out_valid;
    logic [OUT_TDATA_W-1:0] r_out_data;
    logic [OUT_TDATA_W-1:0] n_out_data;

    logic [BTN_W-1:0]      r_ext_press;
    logic [BTN_W-1:0]      r_ext_release;
    logic                  r_ext_repeat;

    logic                  in_xfer;
    logic                  advance;
    logic                  ext_step;
    logic [BTN_W-1:0]      ext_btn;
    t_chan_res             core_res;
    t_chan_res             ext_res;
    t_chan_res             ext_out;
    logic [BTN_W-1:0]      core_last;
    logic [BTN_W-1:0]      ext_last;

    // config registers
    assign cfg_reload   = i_cfg_we;
    assign reload_delay = (i_cfg_idx == CFG_REPEAT_DELAY) ? i_cfg_wdata : r_delay;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_delay    <= DELAY_RESET;
            r_interval <= '0;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                CFG_REPEAT_DELAY:    r_delay    <= i_cfg_wdata;
                CFG_REPEAT_INTERVAL: r_interval <= i_cfg_wdata[INTERVAL_W-1:0];
                default: ;
            endcase
        end
    end

    // handshake
    assign advance    = r_in_valid && (!r_out_valid || i_m_tready);
    assign o_s_tready = !r_in_valid || advance;
    assign in_xfer    = i_s_tvalid && o_s_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_xfer) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_xfer) begin
            r_in_core     <= i_s_tdata[15:0] & CORE_MASK;
            r_in_ext      <= i_s_tdata[31:16];
            r_in_ticks    <= i_s_tdata[41:32];
            r_in_present  <= i_s_tuser[0];
            r_in_suppress <= i_s_tuser[1];
        end
    end

    // channels
    assign ext_step = advance && r_in_present;
    assign ext_btn  = r_in_suppress ? '0 : r_in_ext;

    bear_chan u_core (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (advance),
        .i_reload       (cfg_reload),
        .i_reload_delay (reload_delay),
        .i_delay        (r_delay),
        .i_interval     (r_interval),
        .i_buttons      (r_in_core),
        .i_ticks        (r_in_ticks),
        .o_res          (core_res),
        .o_last_hold    (core_last)
    );

    bear_chan u_ext (
        .i_clk          (i_clk),
        .i_rst_n        (i_rst_n),
        .i_step         (ext_step),
        .i_reload       (cfg_reload),
        .i_reload_delay (reload_delay),
        .i_delay        (r_delay),
        .i_interval     (r_interval),
        .i_buttons      (ext_btn),
        .i_ticks        (r_in_ticks),
        .o_res          (ext_res),
        .o_last_hold    (ext_last)
    );

    // hold the last extension results while it is absent
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ext_press   <= '0;
            r_ext_release <= '0;
            r_ext_repeat  <= 1'b0;
        end else if (ext_step) begin
            r_ext_press   <= ext_res.press;
            r_ext_release <= ext_res.release_;
            r_ext_repeat  <= ext_res.repeat_;
        end
    end

    always_comb begin
        if (r_in_present) begin
            ext_out = ext_res;
        end else begin
            ext_out.hold     = ext_last;
            ext_out.press    = r_ext_press;
            ext_out.release_ = r_ext_release;
            ext_out.repeat_  = r_ext_repeat;
        end
        n_out_data = {6'd0, ext_out.repeat_, ext_out.release_, ext_out.press,
                      ext_out.hold, core_res.repeat_, core_res.release_,
                      core_res.press, core_res.hold};
    end

    // result register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;

    // assertions
    a_in_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_in_valid && !advance) |=> (r_in_valid && $stable(r_in_core)
                                      && $stable(r_in_ticks)))
        else $error("input register lost a poll while stalled");

    a_edges_consistent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        advance |-> (((core_res.press & ~core_res.hold) == '0)
                     && ((core_res.release_ & core_res.hold) == '0)
                     && ((core_res.press & core_last) == '0)))
        else $error("core edges disagree with held state");

    a_ext_absent: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && !r_in_present) |=> (r_out_data[64:49] == $past(ext_last)
                                        && r_out_data[80:65] == $past(r_ext_press)
                                        && r_out_data[97] == $past(r_ext_repeat)))
        else $error("absent extension did not repeat previous results");

    a_core_edge_no_timer: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (advance && (|core_res.release_) && !(|core_res.press)) |-> !core_res.repeat_)
        else $error("repeat raised on a release-only edge");

endmodule
